[hdl/dfa_longest_match_scanner_macros.svh]
// Assertion macros shared by the scanner's checker.
`ifndef DFA_LONGEST_MATCH_SCANNER_MACROS_SVH
`define DFA_LONGEST_MATCH_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while the reset expression is low.
`define DLMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dlms checker: property failed");

// Next-cycle implication, disabled while the reset expression is low.
`define DLMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dlms checker: property failed");

`endif

[hdl/dlms_pkg.sv]
// Package with the types and constants of the DFA longest-match scanner.
`timescale 1ns / 1ps

package dlms_pkg;

    localparam int CHAR_W          = 8;
    localparam int STATE_W         = 4;
    localparam int CLASS_W         = 4;
    localparam int MATCH_END_W     = 12;
    localparam int NUM_STATES      = 16;
    localparam int NUM_CLASSES     = 16;
    localparam int DEFAULT_MAX_LEN = 4096;

    localparam int MAP_DEPTH   = 1 << CHAR_W;
    localparam int TABLE_AW    = STATE_W + CLASS_W;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD_CLASS = 2'd0,
        CMD_LOAD_TRANS = 2'd1,
        CMD_LOAD_FINAL = 2'd2,
        CMD_SCAN       = 2'd3
    } t_cmd;

    // One operation handed from the front to the back. For a scan, cls holds
    // the class looked up from the character; for a transition load it holds
    // the column being written.
    typedef struct packed {
        t_cmd               cmd;
        logic [STATE_W-1:0] state_index;
        logic [CLASS_W-1:0] cls;
        logic [STATE_W-1:0] target;
        logic               is_error;
        logic               final_flag;
        logic               is_last;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic               is_error;
        logic [STATE_W-1:0] target;
    } t_entry;

endpackage

[hdl/dlms_front.sv]
// Front stage: accepts items, owns the class map and looks up each character's class.
`timescale 1ns / 1ps

module dlms_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_command,
    input  logic [dlms_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [dlms_pkg::STATE_W-1:0]  i_state_index,
    input  logic [dlms_pkg::CLASS_W-1:0]  i_class_value,
    input  logic [dlms_pkg::STATE_W-1:0]  i_target_state,
    input  logic                          i_entry_is_error,
    input  logic                          i_final_flag,
    input  logic                          i_is_last,
    input  dlms_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output dlms_pkg::t_op                 o_push_op
);

    logic [dlms_pkg::CLASS_W-1:0] r_class_map [dlms_pkg::MAP_DEPTH];
    logic [dlms_pkg::CLASS_W-1:0] r_map_q;
    logic                         r_fv;
    logic                         n_fv;
    dlms_pkg::t_op                r_fop;
    dlms_pkg::t_cmd               cmd;
    logic                         accept;

    assign cmd     = dlms_pkg::t_cmd'(i_command);
    assign o_push  = r_fv && !i_q_status.full;
    assign o_ready = !r_fv || !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // Class map: written by map loads, read for every accepted item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (cmd == dlms_pkg::CMD_LOAD_CLASS) begin
                r_class_map[i_char_code] <= i_class_value;
            end
            r_map_q <= r_class_map[i_char_code];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fop.cmd         <= cmd;
            r_fop.state_index <= i_state_index;
            r_fop.cls         <= i_class_value;
            r_fop.target      <= i_target_state;
            r_fop.is_error    <= i_entry_is_error;
            r_fop.final_flag  <= i_final_flag;
            r_fop.is_last     <= i_is_last;
        end
    end

    // Map loads finish here and never reach the back.
    always_comb begin
        n_fv = r_fv;
        if (o_push) begin
            n_fv = 1'b0;
        end
        if (accept && cmd != dlms_pkg::CMD_LOAD_CLASS) begin
            n_fv = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_comb begin
        o_push_op = r_fop;
        if (r_fop.cmd == dlms_pkg::CMD_SCAN) begin
            o_push_op.cls = r_map_q;
        end
    end

endmodule

[hdl/dlms_queue.sv]
// Short queue of operations between the front and the back.
`timescale 1ns / 1ps

module dlms_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dlms_pkg::t_op       i_push_op,
    input  logic                i_pop,
    output dlms_pkg::t_q_status o_status,
    output dlms_pkg::t_op       o_head
);

    dlms_pkg::t_op               r_entries [dlms_pkg::QUEUE_DEPTH];
    logic [dlms_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [dlms_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [dlms_pkg::QCNT_W-1:0] r_count;
    logic [dlms_pkg::QCNT_W-1:0] n_count;

    localparam logic [dlms_pkg::QPTR_W-1:0] PTR_LAST =
        dlms_pkg::QPTR_W'(dlms_pkg::QUEUE_DEPTH - 1);
    localparam logic [dlms_pkg::QCNT_W-1:0] CNT_FULL =
        dlms_pkg::QCNT_W'(dlms_pkg::QUEUE_DEPTH);

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_op;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[hdl/dlms_back.sv]
// Back stage: transition table, accepting flags, automaton state and the result register.
`timescale 1ns / 1ps

module dlms_back #(
    parameter int MAX_LEN = dlms_pkg::DEFAULT_MAX_LEN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [dlms_pkg::STATE_W-1:0]       i_start_state,
    input  dlms_pkg::t_q_status                i_q_status,
    input  dlms_pkg::t_op                      i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_matched,
    output logic [dlms_pkg::MATCH_END_W-1:0]   o_match_end,
    output logic                               o_full_match,
    output logic                               o_length_overflow
);

    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int WIDE_W = (POS_W > dlms_pkg::MATCH_END_W) ? POS_W : dlms_pkg::MATCH_END_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN - 1);

    typedef enum logic [1:0] {
        BS_ISSUE = 2'b01,
        BS_EVAL  = 2'b10
    } t_bstate;

    t_bstate r_bs, n_bs;

    dlms_pkg::t_entry                r_table [dlms_pkg::TABLE_DEPTH];
    dlms_pkg::t_entry                r_entry_q;
    logic [dlms_pkg::NUM_STATES-1:0] r_acc_flags;

    logic [dlms_pkg::STATE_W-1:0] r_state, n_state;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [POS_W-1:0]             r_best, n_best;
    logic                         r_have, n_have;
    logic                         r_rej, n_rej;
    logic                         r_ovf, n_ovf;

    logic [dlms_pkg::STATE_W-1:0] r_eff_state;
    logic                         r_step_bad;
    logic                         r_last;

    logic                         r_ov, n_ov;
    logic                         r_o_matched;
    logic [dlms_pkg::MATCH_END_W-1:0] r_o_end;
    logic                         r_o_full;
    logic                         r_o_ovf;

    logic [dlms_pkg::STATE_W-1:0] eff_state;
    logic                         issue_bad;
    logic                         trans_in_range;
    logic                         final_in_range;
    logic                         eval_done;
    logic                         out_load;
    logic [dlms_pkg::STATE_W-1:0] s_state;
    logic [POS_W-1:0]             s_best;
    logic                         s_have;
    logic                         s_rej;
    logic [WIDE_W-1:0]            best_wide;

    // The first character of a string starts from the configured state.
    assign eff_state = (r_pos == '0 && !r_ovf) ? i_start_state : r_state;
    assign issue_bad = (int'(i_head.cls) >= dlms_pkg::NUM_CLASSES) ||
                       (int'(eff_state) >= dlms_pkg::NUM_STATES);
    assign trans_in_range = (int'(i_head.state_index) < dlms_pkg::NUM_STATES) &&
                            (int'(i_head.cls) < dlms_pkg::NUM_CLASSES);
    assign final_in_range = (int'(i_head.state_index) < dlms_pkg::NUM_STATES);

    assign o_pop     = (r_bs == BS_ISSUE) && !i_q_status.empty;
    assign eval_done = !r_last || !r_ov || i_ready;
    assign out_load  = (r_bs == BS_EVAL) && eval_done && r_last;

    // Transition table: one access per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_head.cmd)
                dlms_pkg::CMD_LOAD_TRANS: begin
                    if (trans_in_range) begin
                        r_table[{i_head.state_index, i_head.cls}] <=
                            '{is_error: i_head.is_error, target: i_head.target};
                    end
                end
                dlms_pkg::CMD_SCAN: begin
                    r_entry_q <= r_table[{eff_state, i_head.cls}];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd == dlms_pkg::CMD_LOAD_FINAL && final_in_range) begin
            r_acc_flags[i_head.state_index] <= i_head.final_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd == dlms_pkg::CMD_SCAN) begin
            r_eff_state <= eff_state;
            r_step_bad  <= issue_bad;
            r_last      <= i_head.is_last;
        end
    end

    // Step of the automaton with the fetched entry.
    always_comb begin
        s_state = r_eff_state;
        s_best  = r_best;
        s_have  = r_have;
        s_rej   = r_rej;
        if (!r_rej) begin
            if (r_step_bad || r_entry_q.is_error) begin
                s_rej = 1'b1;
            end else begin
                s_state = r_entry_q.target;
                if (int'(r_entry_q.target) < dlms_pkg::NUM_STATES &&
                    r_acc_flags[r_entry_q.target]) begin
                    s_have = 1'b1;
                    s_best = r_pos;
                end
            end
        end
    end

    assign best_wide = WIDE_W'(s_best);

    always_comb begin
        n_bs    = r_bs;
        n_state = r_state;
        n_pos   = r_pos;
        n_best  = r_best;
        n_have  = r_have;
        n_rej   = r_rej;
        n_ovf   = r_ovf;
        unique case (r_bs)
            BS_ISSUE: begin
                if (o_pop && i_head.cmd == dlms_pkg::CMD_SCAN) begin
                    n_bs = BS_EVAL;
                end
            end
            BS_EVAL: begin
                if (eval_done) begin
                    n_bs = BS_ISSUE;
                    if (r_last) begin
                        n_state = i_start_state;
                        n_pos   = '0;
                        n_best  = '0;
                        n_have  = 1'b0;
                        n_rej   = 1'b0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_state = s_state;
                        n_best  = s_best;
                        n_have  = s_have;
                        n_rej   = s_rej;
                        if (r_pos == POS_MAX) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_bs = BS_ISSUE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs    <= BS_ISSUE;
            r_state <= '0;
            r_pos   <= '0;
            r_best  <= '0;
            r_have  <= 1'b0;
            r_rej   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_bs    <= n_bs;
            r_state <= n_state;
            r_pos   <= n_pos;
            r_best  <= n_best;
            r_have  <= n_have;
            r_rej   <= n_rej;
            r_ovf   <= n_ovf;
        end
    end

    // Result register.
    always_comb begin
        n_ov = r_ov;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        if (out_load) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_matched <= s_have;
            r_o_end     <= s_have ? best_wide[dlms_pkg::MATCH_END_W-1:0] : '0;
            r_o_full    <= s_have && !r_ovf && (s_best == r_pos);
            r_o_ovf     <= r_ovf;
        end
    end

    assign o_valid           = r_ov;
    assign o_matched         = r_o_matched;
    assign o_match_end       = r_o_end;
    assign o_full_match      = r_o_full;
    assign o_length_overflow = r_o_ovf;

endmodule

[hdl/dfa_longest_match_scanner.sv]
// Top level of the table-driven DFA longest-match scanner.
`timescale 1ns / 1ps

// The scanner takes one item per handshake: map loads, transition loads,
// accepting-flag loads and scan characters, in any mix, also in the middle of
// a string. The front stage owns the byte-to-class map and looks up a scanned
// character's class on the cycle it accepts the item; map loads end there.
// Every other item passes through a two-entry queue to the back stage, which
// owns the transition table, the accepting flags and the automaton state.
// A scan item occupies the back for an issue and an evaluate state, since the
// transition table read depends on the state left by the previous character
// and its data is registered; transition and flag loads take only the issue
// state there. The front keeps accepting as long as the queue has room, also
// while the back works or a result waits. With the back idle, the last
// character of a string passes the front register, the queue and the back's
// issue and evaluate states before its result reaches the output register;
// items still ahead of it in the queue and an earlier result that has not
// been taken delay it further. It holds until taken. The position counter is
// $clog2(MAX_LEN) bits wide and saturates at MAX_LEN-1 with the overflow flag
// set. The start state is to be written through the configuration port only
// while the block is idle, which the block does not enforce; it is used at the
// first character of every string. No store is cleared after reset: every
// entry must be loaded before a scan reads it.
module dfa_longest_match_scanner #(
    parameter int MAX_LEN = dlms_pkg::DEFAULT_MAX_LEN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dlms_pkg::STATE_W-1:0]      i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_command,
    input  logic [dlms_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [dlms_pkg::STATE_W-1:0]      i_state_index,
    input  logic [dlms_pkg::CLASS_W-1:0]      i_class_value,
    input  logic [dlms_pkg::STATE_W-1:0]      i_target_state,
    input  logic                              i_entry_is_error,
    input  logic                              i_final_flag,
    input  logic                              i_is_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_matched,
    output logic [dlms_pkg::MATCH_END_W-1:0]  o_match_end,
    output logic                              o_full_match,
    output logic                              o_length_overflow
);

    logic [dlms_pkg::STATE_W-1:0] r_start_state;
    logic                         push;
    logic                         pop;
    dlms_pkg::t_op                push_op;
    dlms_pkg::t_op                head;
    dlms_pkg::t_q_status          q_status;

    // Start state register; the user must write it only between strings, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
        end else if (i_cfg_we) begin
            r_start_state <= i_cfg_wdata;
        end
    end

    dlms_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_char_code      (i_char_code),
        .i_state_index    (i_state_index),
        .i_class_value    (i_class_value),
        .i_target_state   (i_target_state),
        .i_entry_is_error (i_entry_is_error),
        .i_final_flag     (i_final_flag),
        .i_is_last        (i_is_last),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_push_op        (push_op)
    );

    dlms_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_status  (q_status),
        .o_head    (head)
    );

    dlms_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start_state     (r_start_state),
        .i_q_status        (q_status),
        .i_head            (head),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_matched         (o_matched),
        .o_match_end       (o_match_end),
        .o_full_match      (o_full_match),
        .o_length_overflow (o_length_overflow)
    );

endmodule

[hdl/dlms_checker.sv]
// Port-level checker for the scanner and its bind to the top level.
`timescale 1ns / 1ps
`include "dfa_longest_match_scanner_macros.svh"

module dlms_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [dlms_pkg::STATE_W-1:0]      i_cfg_wdata,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic [1:0]                        i_command,
    input logic [dlms_pkg::CHAR_W-1:0]       i_char_code,
    input logic [dlms_pkg::STATE_W-1:0]      i_state_index,
    input logic [dlms_pkg::CLASS_W-1:0]      i_class_value,
    input logic [dlms_pkg::STATE_W-1:0]      i_target_state,
    input logic                              i_entry_is_error,
    input logic                              i_final_flag,
    input logic                              i_is_last,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_matched,
    input logic [dlms_pkg::MATCH_END_W-1:0]  o_match_end,
    input logic                              o_full_match,
    input logic                              o_length_overflow
);

    // A reset leaves no result pending.
    `DLMS_ASSERT_NEXT(a_reset_no_result, i_clk, 1'b1, !i_rst_n, !o_valid)

    // A full match needs a match and a string that fit the counter.
    `DLMS_ASSERT_IMPL(a_full_needs_match, i_clk, i_rst_n, o_valid && o_full_match, o_matched && !o_length_overflow)

    // Without a match the end position and full flag read as zero.
    `DLMS_ASSERT_IMPL(a_no_match_zero, i_clk, i_rst_n, o_valid && !o_matched, o_match_end == '0 && !o_full_match)

    // A stalled result holds its value.
    `DLMS_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_matched) && $stable(o_match_end) && $stable(o_full_match) && $stable(o_length_overflow))

endmodule

bind dfa_longest_match_scanner dlms_checker u_dlms_checker (.*);
